// ===== rtl/pip_pkg.sv =====
package pip_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int COORD_W = 32;
	localparam int ADDR_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int FIELD_W = 32;
	localparam int S_DATA_W = 2 * FIELD_W;
	localparam int M_DATA_W = 8;
	localparam int PROD_W = 2 * COORD_W;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_TEST   = 2'd2
	} pip_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_WALK,
		ST_DRAIN
	} pip_state_t;

	typedef struct packed {
		logic              clear;
		logic              append;
		logic              start_test;
		logic              rd_en;
		logic              rd_edge;
		logic [ADDR_W-1:0] rd_addr;
		logic              load_res;
		logic              res_ovf;
	} pip_ctl_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             full;
		logic             busy;
		logic             slot_free;
	} pip_sts_t;

	function automatic logic [COORD_W:0] sx(input logic [COORD_W-1:0] v);
		return {v[COORD_W-1], v};
	endfunction

	function automatic logic [COORD_W-1:0] abs_mag(input logic [COORD_W:0] v);
		logic [COORD_W:0] n;
		n = v[COORD_W] ? (~v + 1'b1) : v;
		return n[COORD_W-1:0];
	endfunction

	function automatic logic sm_less(input logic na, input logic [PROD_W-1:0] ma,
			input logic nb, input logic [PROD_W-1:0] mb);
		logic r;
		if (na != nb) begin
			r = na;
		end else if (na) begin
			r = ma > mb;
		end else begin
			r = ma < mb;
		end
		return r;
	endfunction

endpackage

// ===== rtl/pip_ram.sv =====
module pip_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/pip_ctrl.sv =====
module pip_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [1:0]       cmd,
	input  pip_pkg::pip_sts_t sts,
	output pip_pkg::pip_ctl_t ctl
);

	pip_pkg::pip_state_t state_q, state_d;
	logic [pip_pkg::CNT_W-1:0] idx_q, idx_d;
	logic [pip_pkg::CNT_W-1:0] count_m1;

	assign count_m1 = sts.count - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pip_pkg::ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		s_tready = 1'b0;
		ctl      = '0;
		unique case (state_q)
			pip_pkg::ST_IDLE: begin
				s_tready = sts.slot_free;
				if (s_tvalid && sts.slot_free) begin
					unique case (cmd)
						pip_pkg::CMD_CLEAR: begin
							ctl.clear = 1'b1;
						end
						pip_pkg::CMD_APPEND: begin
							if (sts.full) begin
								ctl.load_res = 1'b1;
								ctl.res_ovf  = 1'b1;
							end else begin
								ctl.append = 1'b1;
							end
						end
						pip_pkg::CMD_TEST: begin
							ctl.start_test = 1'b1;
							state_d = (sts.count == '0) ? pip_pkg::ST_DRAIN : pip_pkg::ST_PRIME;
						end
						default: begin
						end
					endcase
				end
			end
			pip_pkg::ST_PRIME: begin
				ctl.rd_en   = 1'b1;
				ctl.rd_addr = count_m1[pip_pkg::ADDR_W-1:0];
				idx_d       = '0;
				state_d     = pip_pkg::ST_WALK;
			end
			pip_pkg::ST_WALK: begin
				ctl.rd_en   = 1'b1;
				ctl.rd_edge = 1'b1;
				ctl.rd_addr = idx_q[pip_pkg::ADDR_W-1:0];
				if (idx_q == count_m1) begin
					state_d = pip_pkg::ST_DRAIN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			pip_pkg::ST_DRAIN: begin
				if (!sts.busy && sts.slot_free) begin
					ctl.load_res = 1'b1;
					state_d      = pip_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pip_pkg::ST_IDLE;
			end
		endcase
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_res |-> sts.slot_free)
		else $error("result loaded while output register still holds a result");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_en |-> (pip_pkg::CNT_W'(ctl.rd_addr) < sts.count))
		else $error("vertex read beyond the stored vertices");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pip_pkg::ST_WALK) |-> (idx_q <= count_m1 && sts.count != '0))
		else $error("edge walk index out of range");

	a_count_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != pip_pkg::ST_IDLE) |=> $stable(sts.count))
		else $error("vertex count changed during a test");

endmodule

// ===== rtl/pip_dp.sv =====
module pip_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [pip_pkg::FIELD_W-1:0] coord_x,
	input  logic [pip_pkg::FIELD_W-1:0] coord_y,
	input  pip_pkg::pip_ctl_t          ctl,
	output pip_pkg::pip_sts_t          sts,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic                       inside_res,
	output logic                       overflow
);

	localparam int CW = pip_pkg::COORD_W;

	logic [pip_pkg::CNT_W-1:0] count_q;
	logic [CW-1:0] tx_q, ty_q;
	logic [CW-1:0] prev_x_q, prev_y_q;
	logic [2*CW-1:0] rdata;
	logic rdv_s1, edge_s1;

	logic [CW-1:0] xi, yi;
	logic [CW:0] d, a, b, c;

	logic v_s2, cross_s2, nl_s2, nr_s2, dpos_s2;
	logic [CW-1:0] ma_s2, md_s2, mb_s2, mc_s2;

	logic v_s3, cross_s3, nl_s3, nr_s3, dpos_s3;
	logic [pip_pkg::PROD_W-1:0] ml_s3, mr_s3;
	logic hit;

	logic parity_q;
	logic out_valid_q, inside_q, overflow_q;

	pip_ram #(
		.WIDTH(2 * CW),
		.DEPTH(pip_pkg::MAX_VERTICES)
	) u_vertex_ram (
		.clk  (clk),
		.we   (ctl.append),
		.waddr(count_q[pip_pkg::ADDR_W-1:0]),
		.wdata({coord_y[CW-1:0], coord_x[CW-1:0]}),
		.re   (ctl.rd_en),
		.raddr(ctl.rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear) begin
			count_q <= '0;
		end else if (ctl.append) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start_test) begin
			tx_q <= coord_x[CW-1:0];
			ty_q <= coord_y[CW-1:0];
		end
		if (rdv_s1) begin
			prev_x_q <= xi;
			prev_y_q <= yi;
		end
	end

	assign xi = rdata[CW-1:0];
	assign yi = rdata[2*CW-1:CW];
	assign d  = pip_pkg::sx(prev_y_q) - pip_pkg::sx(yi);
	assign a  = pip_pkg::sx(tx_q) - pip_pkg::sx(xi);
	assign b  = pip_pkg::sx(prev_x_q) - pip_pkg::sx(xi);
	assign c  = pip_pkg::sx(ty_q) - pip_pkg::sx(yi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_s1  <= 1'b0;
			edge_s1 <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			rdv_s1  <= ctl.rd_en;
			edge_s1 <= ctl.rd_en && ctl.rd_edge;
			v_s2    <= edge_s1;
			v_s3    <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		cross_s2 <= ($signed(yi) > $signed(ty_q)) != ($signed(prev_y_q) > $signed(ty_q));
		ma_s2    <= pip_pkg::abs_mag(a);
		md_s2    <= pip_pkg::abs_mag(d);
		mb_s2    <= pip_pkg::abs_mag(b);
		mc_s2    <= pip_pkg::abs_mag(c);
		nl_s2    <= (a[CW] ^ d[CW]) && (a != '0) && (d != '0);
		nr_s2    <= (b[CW] ^ c[CW]) && (b != '0) && (c != '0);
		dpos_s2  <= !d[CW];

		ml_s3    <= ma_s2 * md_s2;
		mr_s3    <= mb_s2 * mc_s2;
		nl_s3    <= nl_s2;
		nr_s3    <= nr_s2;
		dpos_s3  <= dpos_s2;
		cross_s3 <= cross_s2;
	end

	assign hit = dpos_s3 ? pip_pkg::sm_less(nl_s3, ml_s3, nr_s3, mr_s3)
	                     : pip_pkg::sm_less(nr_s3, mr_s3, nl_s3, ml_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
		end else if (ctl.start_test) begin
			parity_q <= 1'b0;
		end else if (v_s3 && cross_s3 && hit) begin
			parity_q <= !parity_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_res) begin
			inside_q   <= ctl.res_ovf ? 1'b0 : parity_q;
			overflow_q <= ctl.res_ovf;
		end
	end

	assign sts.count     = count_q;
	assign sts.full      = count_q == pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES);
	assign sts.busy      = rdv_s1 || v_s2 || v_s3;
	assign sts.slot_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign inside_res = inside_q;
	assign overflow   = overflow_q;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES))
		else $error("vertex count above store depth");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start_test |-> !sts.busy)
		else $error("test started while edges still in flight");

endmodule

// ===== rtl/point_in_polygon_test.sv =====
// Even-odd point-in-polygon test over one polygon of up to 1024 vertices kept in
// a 1024 x 64-bit vertex memory. Each request carries a command in s_tuser: clear
// empties the polygon and append stores one vertex, each with no result; an append
// to a full store is dropped and answered with overflow set. A test reads the
// stored vertices through the memory's single read port, one edge per cycle:
// one priming read of the closing vertex, then n edge reads for n stored
// vertices, then a three-stage subtract, multiply and compare pipeline; for an
// empty store no vertex is read. Requests are taken one at a time; a finished
// result waits in an output register and the next request is taken as soon as
// that register is free or being read.
module point_in_polygon_test (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [pip_pkg::S_DATA_W-1:0] s_tdata,  // coord_x, coord_y
	input  logic [1:0]                   s_tuser,  // cmd
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [pip_pkg::M_DATA_W-1:0] m_tdata,  // inside_res, zero fill
	output logic                         m_tuser   // overflow
);

	pip_pkg::pip_ctl_t ctl;
	pip_pkg::pip_sts_t sts;
	logic inside_res;

	pip_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.cmd     (s_tuser),
		.sts     (sts),
		.ctl     (ctl)
	);

	pip_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.coord_x   (s_tdata[pip_pkg::FIELD_W-1:0]),
		.coord_y   (s_tdata[2*pip_pkg::FIELD_W-1:pip_pkg::FIELD_W]),
		.ctl       (ctl),
		.sts       (sts),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.inside_res(inside_res),
		.overflow  (m_tuser)
	);

	assign m_tdata = {{(pip_pkg::M_DATA_W-1){1'b0}}, inside_res};

endmodule
